@@ sv/gime_pkg.sv @@
// Shared types, codes and constants of the graph incidence matrix engine.
`timescale 1ns / 1ps
package gime_pkg;

  localparam int NUM_ROWS     = 16;
  localparam int NUM_COLS     = 32;
  localparam int ROW_W        = 4;
  localparam int COL_W        = 5;
  localparam int ADDR_W       = ROW_W + COL_W;
  localparam int MEM_DEPTH    = NUM_ROWS * NUM_COLS;
  localparam int RESULT_LIMIT = 32;
  localparam int CFG_W        = 6;

  // command codes on the func field
  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_REMOVE    = 3'd1;
  localparam logic [2:0] FUNC_QUERY_EDGE = 3'd2;
  localparam logic [2:0] FUNC_QUERY_DEG = 3'd3;
  localparam logic [2:0] FUNC_LIST_ADJ  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DIRECTED = 2'd0;
  localparam logic [1:0] CFG_VERTICES = 2'd1;
  localparam logic [1:0] CFG_EDGES    = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         first_vertex;
    logic [3:0]         second_vertex;
    logic [4:0]         edge_index;
    logic signed [15:0] weight;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [3:0]         from_vertex;
    logic [3:0]         to_vertex;
    logic [4:0]         edge_found;
    logic signed [15:0] weight_found;
    logic signed [7:0]  degree;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic       directed;
    logic [4:0] vertices;
    logic [5:0] edges;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_QEDGE  = 3'd2,
    OP_QDEG   = 3'd3,
    OP_ADJ    = 3'd4,
    OP_REJECT = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         a;
    logic [3:0]         b;
    logic [4:0]         e;
    logic signed [15:0] w;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

@@ sv/gime_front.sv @@
// Front end: accepts command words, checks indexes, queues decoded commands.
`timescale 1ns / 1ps
module gime_front
  import gime_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     clearing,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       va, vb, ve;
  cmd_t       dec;

  // index checks against the live register values
  assign va = {1'b0, in_data.first_vertex} < cfg.vertices;
  assign vb = {1'b0, in_data.second_vertex} < cfg.vertices;
  assign ve = {1'b0, in_data.edge_index} < cfg.edges;

  // classify
  always_comb begin
    dec.a  = in_data.first_vertex;
    dec.b  = in_data.second_vertex;
    dec.e  = in_data.edge_index;
    dec.w  = in_data.weight;
    dec.op = OP_REJECT;
    if (in_data.func inside {FUNC_INSERT, FUNC_REMOVE}) begin
      if (va && vb && ve) begin
        dec.op = (in_data.func == FUNC_INSERT) ? OP_INSERT : OP_REMOVE;
      end
    end else if (in_data.func == FUNC_QUERY_EDGE) begin
      if (ve) dec.op = OP_QEDGE;
    end else if (in_data.func == FUNC_QUERY_DEG) begin
      if (va) dec.op = OP_QDEG;
    end else if (in_data.func == FUNC_LIST_ADJ) begin
      if (va) dec.op = OP_ADJ;
    end
  end

  assign in_ready = !clearing && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = q[rd_ptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/gime_back.sv @@
// Back end: executes commands on the incidence memory and degree counters.
`timescale 1ns / 1ps
module gime_back
  import gime_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output back_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_CLR   = 18'h00002,
    ST_RDA   = 18'h00004,
    ST_RDB   = 18'h00008,
    ST_CHK   = 18'h00010,
    ST_WRA   = 18'h00020,
    ST_WRB   = 18'h00040,
    ST_DEGB  = 18'h00080,
    ST_DEGA  = 18'h00100,
    ST_DEGQ  = 18'h00200,
    ST_QRY   = 18'h00400,
    ST_QFIN  = 18'h00800,
    ST_ACOL  = 18'h01000,
    ST_ACOLW = 18'h02000,
    ST_AROW  = 18'h04000,
    ST_AROWW = 18'h08000,
    ST_AFIN  = 18'h10000,
    ST_OUT   = 18'h20000
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic signed [15:0] mem [MEM_DEPTH];
  logic signed [15:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic signed [15:0] wdata;
  logic [ADDR_W-1:0]  clr_addr;
  logic signed [7:0]  deg [NUM_ROWS];
  logic [ROW_W-1:0]   deg_addr;
  logic signed [7:0]  deg_cur;
  logic signed [7:0]  deg_upd;
  logic signed [15:0] neg_w;
  logic               ca_nz;
  logic               cb_nz;
  logic [4:0]         rows;
  logic               p_valid;
  logic [ROW_W-1:0]   p_row;
  logic               exists;
  logic               seen_pos;
  logic [1:0]         cnt;
  logic [3:0]         from_v;
  logic [3:0]         to_v;
  logic signed [15:0] wf;
  logic [5:0]         col;
  logic [4:0]         lrow;
  logic [5:0]         k;
  logic               pend_valid;
  out_word_t          pend;
  out_word_t          res;
  logic               out_free;
  logic               out_load;
  out_word_t          out_load_data;
  logic               hit;
  logic               issue;
  out_word_t          rej_word;

  assign out_free = !out_valid || out_ready;
  assign stat.clearing = (state == ST_CLR);
  assign stat.busy     = (state != ST_IDLE);
  assign neg_w = (cmd.w == 16'sh8000) ? 16'sh7fff : -cmd.w;
  assign issue = rows < cfg.vertices;
  assign hit   = (lrow[ROW_W-1:0] != cmd.a) && (rdata < 16'sd0);

  always_comb begin
    rej_word        = '0;
    rej_word.status = 1'b1;
    rej_word.last   = 1'b1;
  end

  // degree counter read and saturating step
  assign deg_addr = (state == ST_DEGB) ? cmd.b : cmd.a;
  assign deg_cur  = deg[deg_addr];
  always_comb begin
    deg_upd = deg_cur;
    if (cmd.op == OP_INSERT) begin
      if (deg_cur < 8'sd64) deg_upd = deg_cur + 8'sd1;
    end else begin
      if (deg_cur > -8'sd64) deg_upd = deg_cur - 8'sd1;
    end
  end

  // memory port control
  always_comb begin
    raddr = {cmd.a, cmd.e};
    we    = 1'b0;
    waddr = {cmd.a, cmd.e};
    wdata = '0;
    case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      ST_RDB: raddr = {cmd.b, cmd.e};
      ST_WRA: begin
        we    = 1'b1;
        wdata = (cmd.op == OP_INSERT) ? cmd.w : 16'sd0;
      end
      ST_WRB: begin
        we    = 1'b1;
        waddr = {cmd.b, cmd.e};
        if (cmd.op == OP_INSERT) wdata = cfg.directed ? neg_w : cmd.w;
      end
      ST_QRY:            raddr = {rows[ROW_W-1:0], cmd.e};
      ST_ACOL, ST_ACOLW: raddr = {cmd.a, col[COL_W-1:0]};
      ST_AROW, ST_AROWW: raddr = {lrow[ROW_W-1:0], col[COL_W-1:0]};
      default:           raddr = {cmd.a, cmd.e};
    endcase
  end

  // incidence memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // result register loads
  always_comb begin
    out_load      = 1'b0;
    out_load_data = res;
    if (state == ST_OUT && out_free) begin
      out_load = 1'b1;
    end else if (state == ST_AROWW && hit && pend_valid && out_free) begin
      out_load      = 1'b1;
      out_load_data = pend;
    end
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) out_data <= out_load_data;
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      p_valid    <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) deg[i] <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            case (q_cmd.op)
              OP_INSERT, OP_REMOVE: state <= ST_RDA;
              OP_QEDGE: begin
                rows     <= '0;
                p_valid  <= 1'b0;
                exists   <= 1'b0;
                seen_pos <= 1'b0;
                cnt      <= '0;
                from_v   <= '0;
                to_v     <= '0;
                wf       <= '0;
                state    <= ST_QRY;
              end
              OP_QDEG: state <= ST_DEGQ;
              OP_ADJ: begin
                col        <= '0;
                k          <= '0;
                pend_valid <= 1'b0;
                state      <= ST_ACOL;
              end
              default: begin
                res   <= rej_word;
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_RDA: state <= ST_RDB;
        ST_RDB: begin
          ca_nz <= (rdata != 16'sd0);
          state <= ST_CHK;
        end
        ST_CHK: begin
          if ((cmd.op == OP_INSERT && (ca_nz || cb_nz)) ||
              (cmd.op == OP_REMOVE && !ca_nz && !cb_nz)) begin
            res   <= rej_word;
            state <= ST_OUT;
          end else begin
            state <= ST_WRA;
          end
        end
        ST_WRA: state <= ST_WRB;
        ST_WRB: state <= ST_DEGB;
        ST_DEGB: begin
          deg[deg_addr] <= deg_upd;
          state         <= ST_DEGA;
        end
        ST_DEGA: begin
          deg[deg_addr] <= deg_upd;
          res           <= '0;
          res.last      <= 1'b1;
          state         <= ST_OUT;
        end
        ST_DEGQ: begin
          res        <= '0;
          res.degree <= deg_cur;
          res.last   <= 1'b1;
          state      <= ST_OUT;
        end
        // column scan, one row per cycle with one row in flight
        ST_QRY: begin
          if (issue) rows <= rows + 5'd1;
          p_valid <= issue;
          p_row   <= rows[ROW_W-1:0];
          if (p_valid && rdata != 16'sd0) begin
            exists <= 1'b1;
            if (cfg.directed) begin
              if (rdata < 16'sd0) begin
                to_v <= p_row;
              end else begin
                from_v   <= p_row;
                seen_pos <= 1'b1;
                wf       <= rdata;
              end
            end else begin
              if (cnt == 2'd0) begin
                from_v <= p_row;
                wf     <= rdata;
              end else if (cnt == 2'd1) begin
                to_v <= p_row;
              end
              if (cnt != 2'd2) cnt <= cnt + 2'd1;
            end
          end
          if (!issue && !p_valid) state <= ST_QFIN;
        end
        ST_QFIN: begin
          res              <= '0;
          res.found        <= exists;
          res.from_vertex  <= from_v;
          res.to_vertex    <= (!cfg.directed && cnt == 2'd1) ? from_v : to_v;
          res.weight_found <= wf;
          res.last         <= 1'b1;
          state            <= ST_OUT;
        end
        // adjacency: outgoing cell of the vertex, then the column's rows
        ST_ACOL: state <= ST_ACOLW;
        ST_ACOLW: begin
          if (rdata > 16'sd0) begin
            lrow  <= '0;
            state <= ST_AROW;
          end else if (col + 6'd1 >= cfg.edges) begin
            state <= ST_AFIN;
          end else begin
            col   <= col + 6'd1;
            state <= ST_ACOL;
          end
        end
        ST_AROW: state <= ST_AROWW;
        ST_AROWW: begin
          if (!(hit && pend_valid && !out_free)) begin
            if (hit) begin
              pend_valid      <= 1'b1;
              pend            <= '0;
              pend.found      <= 1'b1;
              pend.from_vertex <= cmd.a;
              pend.to_vertex  <= lrow[ROW_W-1:0];
              pend.edge_found <= col[COL_W-1:0];
              k               <= k + 6'd1;
            end
            if (hit && (k + 6'd1 == 6'(RESULT_LIMIT))) begin
              state <= ST_AFIN;
            end else if (lrow + 5'd1 < cfg.vertices) begin
              lrow  <= lrow + 5'd1;
              state <= ST_AROW;
            end else if (col + 6'd1 >= cfg.edges) begin
              state <= ST_AFIN;
            end else begin
              col   <= col + 6'd1;
              state <= ST_ACOL;
            end
          end
        end
        ST_AFIN: begin
          if (pend_valid) begin
            res      <= pend;
            res.last <= 1'b1;
          end else begin
            res             <= '0;
            res.from_vertex <= cmd.a;
            res.last        <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cb_nz = (rdata != 16'sd0);

endmodule

@@ sv/graph_incidence_matrix_engine_top.sv @@
// Top level of the graph incidence matrix engine: registers, front, back.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_ready  | in_word_t command
//  out     | output    | out_valid / out_ready| out_word_t result
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// After reset a clearing pass zeroes the 512-cell memory while in_ready is low.
// Insert/remove read, check and write both cells, then step both degree counters.
// Adjacency list reads the vertex's cell of each column, then each row of hit
// columns, one at a time through the single read port of the incidence memory.
// A two-word command queue lets the front accept while the back works or the
// output word waits; a stalled output only holds the back.
`timescale 1ns / 1ps
module graph_incidence_matrix_engine_top
  import gime_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t       cfg;
  back_stat_t stat;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;

  // configuration registers, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.directed <= 1'b1;
      cfg.vertices <= 5'(NUM_ROWS);
      cfg.edges    <= 6'(NUM_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTED: cfg.directed <= cfg_data[0];
        CFG_VERTICES: begin
          if (cfg_data[4:0] == 5'd0) cfg.vertices <= 5'd1;
          else if (cfg_data[4:0] > 5'(NUM_ROWS)) cfg.vertices <= 5'(NUM_ROWS);
          else cfg.vertices <= cfg_data[4:0];
        end
        CFG_EDGES: begin
          if (cfg_data == 6'd0) cfg.edges <= 6'd1;
          else if (cfg_data > 6'(NUM_COLS)) cfg.edges <= 6'(NUM_COLS);
          else cfg.edges <= cfg_data;
        end
        default: cfg <= cfg;
      endcase
    end
  end

  gime_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (stat.clearing),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  gime_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no command taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !(in_valid && in_ready))
    else $error("command accepted during clearing pass");

  // a rejection is always the single, final word
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.last && !out_data.found)
    else $error("rejected result not a lone final word");

  // queue is drained only while the back end is idle, and taking a command makes it busy
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> stat.busy)
    else $error("back end idle after taking a command");

endmodule
